>>> design/pptq_pkg.sv
// Shared types and constants of the preemptive priority task queue.
package pptq_pkg;

    localparam logic [31:0] IDLE_PRIORITY = 32'h8000_0001;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_FINISH   = 2'd2,
        OP_UNUSED   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_ADDED      = 3'd0,
        ST_FULL       = 3'd1,
        ST_NULL       = 3'd2,
        ST_DISPATCHED = 3'd3,
        ST_EMPTY      = 3'd4,
        ST_HELD       = 3'd5,
        ST_RESTORED   = 3'd6,
        ST_NEST_ERR   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic    load;
        logic    exec;
    } cmd_t;

    typedef struct packed {
        logic    queue_full;
        logic    queue_empty;
        logic    nest_full;
        logic    nest_empty;
        logic    head_held;
    } stat_t;

endpackage

>>> design/pptq_datapath.sv
// Datapath: sorted shift-register queue, nest stack and result register.
module pptq_datapath
    import pptq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int NEST_DEPTH  = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic [1:0]         opcode,
    input  logic [31:0]        task_handle,
    input  logic signed [31:0] task_priority,
    output logic [2:0]         status,
    output logic [31:0]        out_handle,
    output logic signed [31:0] out_priority,
    output logic [6:0]         queued_count,
    output logic [4:0]         nest_depth
);

    localparam int QW = $clog2(QUEUE_DEPTH + 1);
    localparam int NW = $clog2(NEST_DEPTH + 1);
    localparam int NI = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

    logic signed [31:0] prio_reg [QUEUE_DEPTH];
    logic [31:0]        hand_reg [QUEUE_DEPTH];
    logic signed [31:0] saved_mem [NEST_DEPTH];
    logic [QW-1:0]      count_reg;
    logic [NW-1:0]      nest_reg;
    logic signed [31:0] run_reg;
    logic [1:0]         op_reg;
    logic [31:0]        hin_reg;
    logic signed [31:0] pin_reg;
    logic [2:0]         status_reg;
    logic [31:0]        hout_reg;
    logic               is_null;
    logic               do_add;
    logic               do_disp;
    logic               do_fin;
    logic [NI-1:0]      push_idx;
    logic [NI-1:0]      pop_idx;
    logic [2:0]         st_next;

    assign stat.queue_full  = (count_reg >= QW'(QUEUE_DEPTH));
    assign stat.queue_empty = (count_reg == '0);
    assign stat.nest_full   = (nest_reg >= NW'(NEST_DEPTH));
    assign stat.nest_empty  = (nest_reg == '0);
    assign stat.head_held   = (run_reg > prio_reg[0]);

    assign is_null  = (hin_reg == '0);
    assign push_idx = NI'(nest_reg);
    assign pop_idx  = NI'(nest_reg - NW'(1));

    always_comb
    begin
        do_add  = 1'b0;
        do_disp = 1'b0;
        do_fin  = 1'b0;
        st_next = ST_NEST_ERR;
        case (opcode_t'(op_reg))
            OP_ADD:
            begin
                if (is_null)
                    st_next = ST_NULL;
                else if (stat.queue_full)
                    st_next = ST_FULL;
                else
                begin
                    st_next = ST_ADDED;
                    do_add  = 1'b1;
                end
            end
            OP_DISPATCH:
            begin
                if (stat.queue_empty)
                    st_next = ST_EMPTY;
                else if (stat.head_held)
                    st_next = ST_HELD;
                else if (stat.nest_full)
                    st_next = ST_NEST_ERR;
                else
                begin
                    st_next = ST_DISPATCHED;
                    do_disp = 1'b1;
                end
            end
            OP_FINISH:
            begin
                if (stat.nest_empty)
                    st_next = ST_NEST_ERR;
                else
                begin
                    st_next = ST_RESTORED;
                    do_fin  = 1'b1;
                end
            end
            default: st_next = ST_NEST_ERR;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            hin_reg <= task_handle;
            pin_reg <= task_priority;
        end
        if (cmd.exec)
        begin
            status_reg <= st_next;
            hout_reg   <= do_disp ? hand_reg[0] : '0;
        end
    end

    // Each cell either holds, takes the new item, takes its left neighbor, or its right one.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic keep_here;
        logic keep_left;
        assign keep_here = (QW'(i) >= count_reg) || (prio_reg[i] < pin_reg);
        if (i == 0)
        begin : g_first
            assign keep_left = 1'b0;
        end
        else
        begin : g_rest
            assign keep_left = (QW'(i - 1) < count_reg) && (prio_reg[i - 1] < pin_reg);
        end
        always_ff @(posedge clk)
        begin
            if (cmd.exec && do_add && keep_here)
            begin
                if (keep_left)
                begin
                    prio_reg[i] <= prio_reg[(i == 0) ? 0 : i - 1];
                    hand_reg[i] <= hand_reg[(i == 0) ? 0 : i - 1];
                end
                else
                begin
                    prio_reg[i] <= pin_reg;
                    hand_reg[i] <= hin_reg;
                end
            end
            else if (cmd.exec && do_disp && (i < QUEUE_DEPTH - 1))
            begin
                prio_reg[i] <= prio_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                hand_reg[i] <= hand_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && do_disp)
            saved_mem[push_idx] <= run_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            nest_reg  <= '0;
            run_reg   <= IDLE_PRIORITY;
        end
        else if (cmd.exec)
        begin
            if (do_add)
                count_reg <= count_reg + QW'(1);
            if (do_disp)
            begin
                count_reg <= count_reg - QW'(1);
                nest_reg  <= nest_reg + NW'(1);
                run_reg   <= prio_reg[0];
            end
            if (do_fin)
            begin
                nest_reg <= nest_reg - NW'(1);
                run_reg  <= saved_mem[pop_idx];
            end
        end
    end

    assign status       = status_reg;
    assign out_handle   = hout_reg;
    assign out_priority = run_reg;
    assign queued_count = 7'(count_reg);
    assign nest_depth   = 5'(nest_reg);

endmodule

>>> design/pptq_ctrl.sv
// Controller: sequences capture, execution and result transfer.
module pptq_ctrl
    import pptq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
                if (out_ready)
                begin
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_EXEC;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> design/preemptive_priority_task_queue_top.sv
// Top level of the preemptive priority task queue.
// The input channel carries an opcode (add, dispatch, finish), a task handle
// and a signed priority; each item gives exactly one result transfer with a
// status, the dispatched handle, the running priority, and the queue and
// nest counts after the operation.
// An item is captured on its transfer, executed in the next cycle against
// the sorted shift-register queue and the nest stack, and presented in the
// cycle after that from the result register.
// The next item is taken in the same cycle as the result transfer, so items
// do not overlap: each passes the capture and execute steps before the next.
// Reset empties the queue and nest stack and sets the running priority to the
// idle marker. When the receiver stalls, the result holds and no new item is
// taken until it is transferred.
module preemptive_priority_task_queue_top
    import pptq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int NEST_DEPTH  = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [31:0]        task_handle,
    input  logic signed [31:0] task_priority,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [31:0]        out_handle,
    output logic signed [31:0] out_priority,
    output logic [6:0]         queued_count,
    output logic [4:0]         nest_depth
);

    cmd_t  cmd;
    stat_t stat;

    pptq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    pptq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NEST_DEPTH  (NEST_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (opcode),
        .task_handle   (task_handle),
        .task_priority (task_priority),
        .status        (status),
        .out_handle    (out_handle),
        .out_priority  (out_priority),
        .queued_count  (queued_count),
        .nest_depth    (nest_depth)
    );

endmodule
